@@ rtl/core/rbs_pkg.sv @@
// Shared types, codes and constants of the refresh back-off scheduler.
`default_nettype none

package rbs_pkg;

    localparam int DEFAULT_NUM_SLOTS = 8;

    localparam int SLOT_W     = 3;
    localparam int TIME_W     = 32;
    localparam int FAIL_W     = 3;
    localparam int INTERVAL_W = 5;
    localparam int ACTIVE_W   = 4;
    localparam int CFG_DATA_W = 5;
    localparam int BASE_W     = 11;
    localparam int BACKOFF_W  = 16;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 5'd5;
    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET   = 4'd8;
    localparam logic [FAIL_W-1:0]     MAX_FAILS      = 3'd5;
    localparam logic [BASE_W-1:0]     SEC_PER_MIN    = 11'd60;
    localparam logic [BASE_W-1:0]     BACKOFF_CAP    = 11'd1800;

    typedef enum logic [1:0] {
        OP_CHECK     = 2'd0,
        OP_REPORT    = 2'd1,
        OP_FORCE     = 2'd2,
        OP_FORCE_ALL = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        SHOWN_FRESH = 2'd0,
        SHOWN_STALE = 2'd1,
        SHOWN_ERROR = 2'd2
    } shown_e;

    typedef enum logic {
        CFG_INTERVAL = 1'b0,
        CFG_ACTIVE   = 1'b1
    } cfg_idx_e;

    typedef struct packed {
        op_e               op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_seconds;
        logic              link_up;
        logic              slot_enabled;
        logic              fetch_ok;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              fetch_now;
        logic [TIME_W-1:0] next_due;
        logic [FAIL_W-1:0] fail_streak;
        logic              has_data;
        logic [1:0]        shown_state;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic execute;
    } rbs_cmd_t;

    // Only 1, 5, 15 and 30 minutes are legal base intervals.
    function automatic logic interval_legal(input logic [INTERVAL_W-1:0] m);
        logic ok;
        ok = (m == 5'd1) || (m == 5'd5) || (m == 5'd15) || (m == 5'd30);
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rbs_in_if.sv @@
// Valid/ready channel that carries input words of the scheduler.
`default_nettype none

interface rbs_in_if;
    import rbs_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rbs_out_if.sv @@
// Valid/ready channel that carries result words of the scheduler.
`default_nettype none

interface rbs_out_if;
    import rbs_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rbs_ctrl.sv @@
// Controller state machine of the refresh back-off scheduler.
`default_nettype none

module rbs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rbs_pkg::rbs_cmd_t     cmd
);
    import rbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // A new word is taken only once the result register is free or drains now.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rbs_dp.sv @@
// Datapath of the refresh back-off scheduler: slot table, back-off math, result register.
`default_nettype none

module rbs_dp #(
    parameter int NUM_SLOTS = rbs_pkg::DEFAULT_NUM_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rbs_pkg::rbs_cmd_t              cmd,
    input  wire rbs_pkg::in_word_t              in_word,
    output rbs_pkg::out_word_t                  out_word,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_idx,
    input  wire logic [rbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rbs_pkg::*;

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_RAW = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W   = (CNT_RAW > ACTIVE_W) ? CNT_RAW : ACTIVE_W;

    logic [TIME_W-1:0]     due_reg      [NUM_SLOTS];
    logic [TIME_W-1:0]     due_next     [NUM_SLOTS];
    logic [FAIL_W-1:0]     fails_reg    [NUM_SLOTS];
    logic [FAIL_W-1:0]     fails_next   [NUM_SLOTS];
    logic [1:0]            shown_reg    [NUM_SLOTS];
    logic [1:0]            shown_next   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  forced_reg;
    logic [NUM_SLOTS-1:0]  forced_next;
    logic [NUM_SLOTS-1:0]  data_reg;
    logic [NUM_SLOTS-1:0]  data_next;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [ACTIVE_W-1:0]   active_reg;
    in_word_t              item_reg;
    out_word_t             out_reg;
    out_word_t             out_next;

    logic [CNT_W-1:0]      active_cnt;
    logic                  slot_active;
    logic [IDX_W+SLOT_W-1:0] slot_wide;
    logic [IDX_W-1:0]      idx;
    logic                  cfg_force;
    logic [BASE_W-1:0]     base;
    logic [FAIL_W-1:0]     fails_inc;
    logic [BACKOFF_W-1:0]  shifted;
    logic [BASE_W-1:0]     backoff;
    logic [BASE_W-1:0]     delay;
    logic [TIME_W:0]       sum;
    logic [TIME_W-1:0]     sched;
    logic                  fetch;

    assign active_cnt  = (CNT_W'(active_reg) < CNT_W'(NUM_SLOTS)) ?
                         CNT_W'(active_reg) : CNT_W'(NUM_SLOTS);
    assign slot_active = CNT_W'(item_reg.slot) < active_cnt;
    assign slot_wide   = {{IDX_W{1'b0}}, item_reg.slot};
    assign idx         = slot_wide[IDX_W-1:0];
    assign cfg_force   = cfg_we && (cfg_idx == CFG_INTERVAL) && interval_legal(cfg_wdata);

    // Back-off: base times 2^(new fail count), capped, then a saturating add to now.
    assign base      = BASE_W'(interval_reg) * SEC_PER_MIN;
    assign fails_inc = (fails_reg[idx] < MAX_FAILS) ? fails_reg[idx] + 3'd1 : MAX_FAILS;
    assign shifted   = BACKOFF_W'(base) << fails_inc;
    assign backoff   = (shifted > BACKOFF_W'(BACKOFF_CAP)) ? BACKOFF_CAP : shifted[BASE_W-1:0];
    assign delay     = item_reg.fetch_ok ? base : backoff;
    assign sum       = {1'b0, item_reg.now_seconds} + (TIME_W + 1)'(delay);
    assign sched     = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    assign fetch     = item_reg.slot_enabled
                    && (item_reg.link_up || forced_reg[idx])
                    && (forced_reg[idx] || (item_reg.now_seconds >= due_reg[idx]));

    always_comb
    begin
        due_next    = due_reg;
        fails_next  = fails_reg;
        shown_next  = shown_reg;
        forced_next = forced_reg;
        data_next   = data_reg;
        out_next    = out_reg;

        if (cfg_force || (cmd.execute && (item_reg.op == OP_FORCE_ALL)))
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (CNT_W'(i) < active_cnt)
                begin
                    forced_next[i] = 1'b1;
                    due_next[i]    = '0;
                end
            end
        end

        if (cmd.execute)
        begin
            if (slot_active)
            begin
                unique case (item_reg.op)
                    OP_CHECK:
                    begin
                        if (fetch)
                        begin
                            forced_next[idx] = 1'b0;
                        end
                    end
                    OP_REPORT:
                    begin
                        due_next[idx] = sched;
                        if (item_reg.fetch_ok)
                        begin
                            fails_next[idx] = '0;
                            data_next[idx]  = 1'b1;
                            shown_next[idx] = SHOWN_FRESH;
                        end
                        else
                        begin
                            fails_next[idx] = fails_inc;
                            shown_next[idx] = data_reg[idx] ? SHOWN_STALE : SHOWN_ERROR;
                        end
                    end
                    OP_FORCE:
                    begin
                        forced_next[idx] = 1'b1;
                        due_next[idx]    = '0;
                    end
                    OP_FORCE_ALL:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end

            out_next.slot_out = item_reg.slot;
            if (slot_active)
            begin
                out_next.fetch_now   = (item_reg.op == OP_CHECK) && fetch;
                out_next.next_due    = due_next[idx];
                out_next.fail_streak = fails_next[idx];
                out_next.has_data    = data_next[idx];
                out_next.shown_state = shown_next[idx];
            end
            else
            begin
                out_next.fetch_now   = 1'b0;
                out_next.next_due    = '0;
                out_next.fail_streak = '0;
                out_next.has_data    = 1'b0;
                out_next.shown_state = SHOWN_FRESH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                due_reg[i]   <= '0;
                fails_reg[i] <= '0;
                shown_reg[i] <= SHOWN_ERROR;
            end
            forced_reg   <= '0;
            data_reg     <= '0;
            interval_reg <= INTERVAL_RESET;
            active_reg   <= ACTIVE_RESET;
        end
        else
        begin
            due_reg    <= due_next;
            fails_reg  <= fails_next;
            shown_reg  <= shown_next;
            forced_reg <= forced_next;
            data_reg   <= data_next;
            if (cfg_force)
            begin
                interval_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_idx == CFG_ACTIVE))
            begin
                active_reg <= cfg_wdata[ACTIVE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_word;
        end
        out_reg <= out_next;
    end

    assign out_word = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/refresh_backoff_scheduler.sv @@
// Top level of the refresh back-off scheduler.
`default_nettype none

// Refresh scheduler with exponential back-off over a table of NUM_SLOTS slots.
// Each input word carries one op: a check that says whether a slot must fetch
// now, a report that applies a fetch outcome and schedules the next fetch, a
// force of one slot, or a force of every active slot. Every word yields exactly
// one result word with the addressed slot's state after the op; ops on slots at
// or above the active count report zeros and change nothing, except that a
// force of every active slot still acts. A word is first registered; then the
// slot table is read and updated and the result register is loaded. The block
// takes no new word while one is in work, and takes one as soon as the result
// register is empty or is being drained in the same cycle. Successful
// fetches reschedule at now plus interval*60 seconds; failures reschedule at
// now plus interval*60*2^failures capped at 1800 seconds, and all time sums
// saturate at 2^32-1. Configuration is written through cfg_we, cfg_idx and
// cfg_wdata. The user must write only while idle; the block does not enforce it.
// Index 0 sets the interval in minutes (only 1, 5, 15 and 30 are taken, and a
// taken write forces every active slot); index 1 sets the number of active slots.
module refresh_backoff_scheduler #(
    parameter int NUM_SLOTS = rbs_pkg::DEFAULT_NUM_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    rbs_in_if.sink                              req,
    rbs_out_if.source                           rsp,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_idx,
    input  wire logic [rbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rbs_pkg::*;

    rbs_cmd_t cmd;

    // The controller sequences the load and execute steps and owns both handshakes.
    rbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath holds the slot table, configuration and result register.
    rbs_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (req.data),
        .out_word  (rsp.data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/rbs_checker.sv @@
// Port-level checker of the refresh back-off scheduler and its bind.
`default_nettype none

module rbs_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire rbs_pkg::out_word_t rsp_data
);
    import rbs_pkg::*;

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word changed while stalled");

    // Words are worked one at a time: no accept right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input accepted while previous word in flight");

    // The failure count saturates at five.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.fail_streak <= MAX_FAILS)
        else $error("fail count above saturation");

    // Stale means data is kept, error means no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_data.shown_state == SHOWN_STALE) && rsp_data.has_data)
                   || ((rsp_data.shown_state == SHOWN_ERROR) && !rsp_data.has_data)
                   || (rsp_data.shown_state == SHOWN_FRESH))
        else $error("shown state disagrees with data flag");

    // A slot with data and no failures is shown as fresh.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.has_data && (rsp_data.fail_streak == '0)
        |-> rsp_data.shown_state == SHOWN_FRESH)
        else $error("clean slot with data not shown fresh");

endmodule

bind refresh_backoff_scheduler rbs_checker u_rbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the refresh back-off scheduler.
`timescale 1ns / 1ps

module tb_top;
    import rbs_pkg::*;

    localparam int SLOTS       = DEFAULT_NUM_SLOTS;
    localparam int HOLD_CYCLES = 90;    // one long stall on the result side
    localparam int HOLD_AT     = 400;   // result count at which that stall starts
    localparam int SETTLE      = 4;     // cycles past the last result before a register write

    // Kind of a row in the directed stimulus table.
    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_e;

    typedef struct {
        row_kind_e         kind;
        in_word_t          word;
        logic              typed;   // expectation written into the table by hand
        out_word_t         res;
        cfg_idx_e          reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_e cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rbs_in_if  req_ch ();
    rbs_out_if rsp_ch ();

    refresh_backoff_scheduler #(
        .NUM_SLOTS (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the slot table and of the two registers. It is updated
    // whenever a word is accepted or a register is written, so the expected
    // result of each word is known the moment the block takes it.
    logic [TIME_W-1:0]     due_at     [SLOTS];
    logic [FAIL_W-1:0]     fail_cnt   [SLOTS];
    logic                  force_flag [SLOTS];
    logic                  data_flag  [SLOTS];
    logic                  busy_flag  [SLOTS];
    shown_e                shown      [SLOTS];
    logic [INTERVAL_W-1:0] interval_min;
    logic [ACTIVE_W-1:0]   active_reg;

    // Results the block still owes us, oldest first.
    out_word_t pending_results [$];
    dir_row_t  directed_rows [$];

    int mismatches;
    int results_seen;
    int words_sent;
    int reg_writes;
    int grants;
    int failed_reports;
    int inactive_words;
    int hold_left;
    bit hold_done;
    bit steady;          // when set, neither side inserts idle cycles
    int last_grant;      // slot that was last told to fetch, -1 if none
    logic [TIME_W-1:0] wall_clock;

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------

    function automatic int slots_in_use();
        return (int'(active_reg) > SLOTS) ? SLOTS : int'(active_reg);
    endfunction

    function automatic void force_active_slots();
        for (int i = 0; i < slots_in_use(); i++) begin
            force_flag[i] = 1'b1;
            due_at[i]     = '0;
        end
    endfunction

    // Time sums clamp at the top of the 32-bit range instead of wrapping.
    function automatic logic [TIME_W-1:0] clamp_add(logic [TIME_W-1:0] a,
                                                     logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic void reset_schedule();
        for (int i = 0; i < SLOTS; i++) begin
            due_at[i]     = '0;
            fail_cnt[i]   = '0;
            force_flag[i] = 1'b0;
            data_flag[i]  = 1'b0;
            busy_flag[i]  = 1'b0;
            shown[i]      = SHOWN_ERROR;
        end
        interval_min = INTERVAL_RESET;
        active_reg   = ACTIVE_RESET;
    endfunction

    // A taken interval write also forces every slot that is in use; an
    // interval outside the four legal values leaves everything alone.
    function automatic void apply_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
        logic [INTERVAL_W-1:0] m;
        m = val[INTERVAL_W-1:0];
        if (idx == CFG_INTERVAL) begin
            if (m == 5'd1 || m == 5'd5 || m == 5'd15 || m == 5'd30) begin
                interval_min = m;
                force_active_slots();
            end
        end else begin
            active_reg = val[ACTIVE_W-1:0];
        end
    endfunction

    // Applies one word to the shadow table and returns the result it causes.
    function automatic out_word_t predict_slot_result(in_word_t w);
        out_word_t r;
        int s;
        logic active;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] wait_s;
        r      = '0;
        s      = int'(w.slot);
        active = (s < slots_in_use());
        r.slot_out = w.slot;
        if (w.op == OP_FORCE_ALL) begin
            force_active_slots();
        end else if (active) begin
            case (w.op)
                OP_CHECK: begin
                    // Forcing overrides both a down link and a future due time.
                    if (w.slot_enabled && (w.link_up || force_flag[s]) &&
                        (force_flag[s] || w.now_seconds >= due_at[s])) begin
                        r.fetch_now   = 1'b1;
                        force_flag[s] = 1'b0;
                        busy_flag[s]  = 1'b1;
                    end
                end
                OP_REPORT: begin
                    base = TIME_W'(interval_min) * 32'd60;
                    if (w.fetch_ok) begin
                        data_flag[s] = 1'b1;
                        shown[s]     = SHOWN_FRESH;
                        fail_cnt[s]  = '0;
                        due_at[s]    = clamp_add(w.now_seconds, base);
                    end else begin
                        shown[s] = data_flag[s] ? SHOWN_STALE : SHOWN_ERROR;
                        if (fail_cnt[s] < MAX_FAILS)
                            fail_cnt[s] = fail_cnt[s] + 1'b1;
                        wait_s = base << fail_cnt[s];
                        if (wait_s > 32'd1800)
                            wait_s = 32'd1800;
                        due_at[s] = clamp_add(w.now_seconds, wait_s);
                    end
                    busy_flag[s] = 1'b0;
                end
                OP_FORCE: begin
                    force_flag[s] = 1'b1;
                    due_at[s]     = '0;
                end
                default: ;
            endcase
        end
        if (active) begin
            r.next_due    = due_at[s];
            r.fail_streak = fail_cnt[s];
            r.has_data    = data_flag[s];
            r.shown_state = shown[s];
        end
        return r;
    endfunction

    //------------------------------------------------------------------
    // Directed table helpers
    //------------------------------------------------------------------

    function automatic in_word_t mk_word(op_e op, int slot, logic [TIME_W-1:0] now,
                                         logic link, logic en, logic ok);
        in_word_t w;
        w.op           = op;
        w.slot         = SLOT_W'(slot);
        w.now_seconds  = now;
        w.link_up      = link;
        w.slot_enabled = en;
        w.fetch_ok     = ok;
        return w;
    endfunction

    function automatic out_word_t mk_result(int slot, logic fetch, logic [TIME_W-1:0] due,
                                            int fails, logic data, shown_e sh);
        out_word_t r;
        r.slot_out    = SLOT_W'(slot);
        r.fetch_now   = fetch;
        r.next_due    = due;
        r.fail_streak = FAIL_W'(fails);
        r.has_data    = data;
        r.shown_state = sh;
        return r;
    endfunction

    function automatic void add_word(in_word_t w, logic typed, out_word_t res);
        dir_row_t row;
        row.kind    = ROW_WORD;
        row.word    = w;
        row.typed   = typed;
        row.res     = res;
        row.reg_idx = CFG_INTERVAL;
        row.reg_val = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row.kind    = ROW_REG;
        row.word    = '0;
        row.typed   = 1'b0;
        row.res     = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------

    // Offers one word and returns once the block has taken it. The expected
    // result is worked out at the accepting edge. Random idle cycles go in
    // ahead of the word unless the run is in a steady stretch or the result
    // side is holding off, where we want the input to back up.
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t typed_res,
                             output out_word_t predicted);
        if (!steady && hold_left == 0) begin
            while ($urandom_range(0, 99) < 34) begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_slot_result(w);
        pending_results.push_back(typed ? typed_res : predicted);
        words_sent++;
        if (predicted.fetch_now)
            grants++;
        if (w.op == OP_REPORT && !w.fetch_ok)
            failed_reports++;
        if (int'(w.slot) >= slots_in_use())
            inactive_words++;
    endtask

    // Stops offering words and waits until every owed result has come back,
    // plus a settling pause so the block is truly quiet.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        apply_register(idx, val);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random words shaped like real traffic: a wall clock that moves forward,
    // most words on slots in use, and a granted check usually followed by a
    // report for the same slot. The rest is noise: arbitrary or near-maximum
    // times, inactive slots and reports that nobody asked for.
    task automatic run_random(input int count, input int drain_at);
        in_word_t  w;
        out_word_t got;
        int r;
        int n;
        for (int k = 0; k < count; k++) begin
            if (k == drain_at)
                wait_until_drained();
            n = slots_in_use();
            r = $urandom_range(0, 99);
            if (last_grant >= 0 && $urandom_range(0, 99) < 70) begin
                w.op   = OP_REPORT;
                w.slot = SLOT_W'(last_grant);
            end else begin
                if (r < 40)
                    w.op = OP_CHECK;
                else if (r < 72)
                    w.op = OP_REPORT;
                else if (r < 92)
                    w.op = OP_FORCE;
                else
                    w.op = OP_FORCE_ALL;
                if (n > 0 && $urandom_range(0, 99) < 85)
                    w.slot = SLOT_W'($urandom_range(0, n - 1));
                else
                    w.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                wall_clock    = wall_clock + $urandom_range(0, 500);
                w.now_seconds = wall_clock;
            end else if (r < 90) begin
                w.now_seconds = $urandom;
            end else begin
                w.now_seconds = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            end
            w.link_up      = ($urandom_range(0, 99) < 80);
            w.slot_enabled = ($urandom_range(0, 99) < 85);
            w.fetch_ok     = ($urandom_range(0, 99) < 60);
            send_word(w, 1'b0, '0, got);
            if (w.op == OP_CHECK && got.fetch_now)
                last_grant = int'(w.slot);
            else if (w.op == OP_REPORT)
                last_grant = -1;
        end
    endtask

    //------------------------------------------------------------------
    // Result side
    //------------------------------------------------------------------

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (pending_results.size() == 0) begin
            $error("result word for slot %0d arrived with nothing expected", got.slot_out);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            if (got.slot_out !== want.slot_out) begin
                $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
                mismatches++;
            end
            if (got.fetch_now !== want.fetch_now) begin
                $error("fetch_now: expected %0d, got %0d", want.fetch_now, got.fetch_now);
                mismatches++;
            end
            if (got.next_due !== want.next_due) begin
                $error("next_due: expected %0d, got %0d", want.next_due, got.next_due);
                mismatches++;
            end
            if (got.fail_streak !== want.fail_streak) begin
                $error("fail_streak: expected %0d, got %0d", want.fail_streak,
                       got.fail_streak);
                mismatches++;
            end
            if (got.has_data !== want.has_data) begin
                $error("has_data: expected %0d, got %0d", want.has_data, got.has_data);
                mismatches++;
            end
            if (got.shown_state !== want.shown_state) begin
                $error("shown_state: expected %0d, got %0d", want.shown_state, got.shown_state);
                mismatches++;
            end
        end
    endtask

    // The receiver stalls at random, except in steady stretches, and once,
    // after HOLD_AT results, holds ready low for a long counted stretch
    // so that the block fills up and pushes back on the input.
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                check_result(rsp_ch.data);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    //------------------------------------------------------------------
    // Clock, reset and the watchdog
    //------------------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The slowest correct run is well under a tenth of this.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------

    initial begin
        out_word_t got;
        mismatches     = 0;
        results_seen   = 0;
        words_sent     = 0;
        reg_writes     = 0;
        grants         = 0;
        failed_reports = 0;
        inactive_words = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        steady         = 1'b0;
        last_grant     = -1;
        wall_clock     = '0;
        reset_schedule();

        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_INTERVAL;
        cfg_wdata    <= '0;

        // Directed table. Typed rows follow straight from the rules: the
        // state just after reset, the back-off ladder up to its cap and the
        // saturating failure count, clamped time sums, forcing past a down
        // link, and the all-zero answer for slots outside the active range.
        // Rows up to the first interval write run with the 5 minute reset interval (300 s).
        add_word(mk_word(OP_CHECK, 0, 0, 1, 1, 0), 1, mk_result(0, 1, 0, 0, 0, SHOWN_ERROR));
        add_word(mk_word(OP_CHECK, 1, 0, 1, 0, 0), 1, mk_result(1, 0, 0, 0, 0, SHOWN_ERROR));
        add_word(mk_word(OP_CHECK, 2, 100, 0, 1, 1), 1, mk_result(2, 0, 0, 0, 0, SHOWN_ERROR));
        add_word(mk_word(OP_REPORT, 0, 1000, 0, 0, 1), 1,
                 mk_result(0, 0, 1300, 0, 1, SHOWN_FRESH));
        add_word(mk_word(OP_REPORT, 0, 2000, 1, 1, 0), 1,
                 mk_result(0, 0, 2600, 1, 1, SHOWN_STALE));
        add_word(mk_word(OP_REPORT, 0, 32'hFFFF_FFFF, 1, 1, 0), 1,
                 mk_result(0, 0, 32'hFFFF_FFFF, 2, 1, SHOWN_STALE));
        add_word(mk_word(OP_REPORT, 0, 0, 1, 1, 0), 1, mk_result(0, 0, 1800, 3, 1, SHOWN_STALE));
        add_word(mk_word(OP_REPORT, 0, 10, 1, 1, 0), 1, mk_result(0, 0, 1810, 4, 1, SHOWN_STALE));
        add_word(mk_word(OP_REPORT, 0, 10, 1, 1, 0), 1, mk_result(0, 0, 1810, 5, 1, SHOWN_STALE));
        add_word(mk_word(OP_REPORT, 0, 20, 1, 1, 0), 1, mk_result(0, 0, 1820, 5, 1, SHOWN_STALE));
        add_word(mk_word(OP_REPORT, 3, 5, 1, 1, 0), 1, mk_result(3, 0, 605, 1, 0, SHOWN_ERROR));
        add_word(mk_word(OP_CHECK, 0, 100, 1, 1, 0), 1, mk_result(0, 0, 1820, 5, 1, SHOWN_STALE));
        add_word(mk_word(OP_FORCE, 0, 32'hFFFF_FFFF, 0, 0, 1), 1,
                 mk_result(0, 0, 0, 5, 1, SHOWN_STALE));
        add_word(mk_word(OP_CHECK, 0, 0, 0, 1, 0), 1, mk_result(0, 1, 0, 5, 1, SHOWN_STALE));
        add_word(mk_word(OP_CHECK, 0, 0, 0, 1, 0), 1, mk_result(0, 0, 0, 5, 1, SHOWN_STALE));
        add_word(mk_word(OP_FORCE_ALL, 7, 0, 0, 0, 0), 1, mk_result(7, 0, 0, 0, 0, SHOWN_ERROR));
        add_word(mk_word(OP_CHECK, 5, 0, 0, 1, 0), 1, mk_result(5, 1, 0, 0, 0, SHOWN_ERROR));
        add_word(mk_word(OP_REPORT, 5, 32'hFFFF_FF00, 1, 1, 1), 1,
                 mk_result(5, 0, 32'hFFFF_FFFF, 0, 1, SHOWN_FRESH));
        // Three slots in use: words on slots 3 and up change nothing, save that a force-all still forces slots 0 to 2.
        add_reg(CFG_ACTIVE, 5'd3);
        add_word(mk_word(OP_CHECK, 5, 0, 1, 1, 0), 1, mk_result(5, 0, 0, 0, 0, SHOWN_FRESH));
        add_word(mk_word(OP_REPORT, 3, 50, 1, 1, 1), 1, mk_result(3, 0, 0, 0, 0, SHOWN_FRESH));
        add_word(mk_word(OP_FORCE_ALL, 4, 0, 1, 1, 1), 1, mk_result(4, 0, 0, 0, 0, SHOWN_FRESH));
        // A 15 minute interval is taken; 0 and 31 are not.
        add_reg(CFG_INTERVAL, 5'd15);
        add_reg(CFG_INTERVAL, 5'd0);
        add_reg(CFG_INTERVAL, 5'd31);
        add_word(mk_word(OP_REPORT, 1, 0, 1, 1, 0), 1, mk_result(1, 0, 1800, 1, 0, SHOWN_ERROR));
        add_word(mk_word(OP_REPORT, 1, 0, 1, 1, 1), 1, mk_result(1, 0, 900, 0, 1, SHOWN_FRESH));
        // No slot in use at all.
        add_reg(CFG_ACTIVE, 5'd0);
        add_word(mk_word(OP_CHECK, 0, 0, 1, 1, 0), 1, mk_result(0, 0, 0, 0, 0, SHOWN_FRESH));
        // Counts above the table size mean the whole table.
        add_reg(CFG_ACTIVE, 5'd15);
        add_reg(CFG_INTERVAL, 5'd1);
        add_word(mk_word(OP_REPORT, 6, 0, 0, 0, 0), 1, mk_result(6, 0, 120, 1, 0, SHOWN_ERROR));
        add_reg(CFG_INTERVAL, 5'd30);
        add_word(mk_word(OP_REPORT, 6, 7, 0, 0, 0), 0, '0);
        add_word(mk_word(OP_CHECK, 6, 32'hFFFF_FFFF, 1, 0, 1), 0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_word(directed_rows[i].word, directed_rows[i].typed,
                          directed_rows[i].res, got);
        end

        // Random phases over a spread of register settings.
        write_reg(CFG_ACTIVE, 5'd8);
        write_reg(CFG_INTERVAL, 5'd5);
        run_random(250, -1);

        // Smallest interval with a single slot in use. The long hold-off on
        // the result side lands in this phase.
        write_reg(CFG_INTERVAL, 5'd1);
        write_reg(CFG_ACTIVE, 5'd1);
        run_random(150, -1);

        // Largest interval, full table, and no idle cycles on either side.
        write_reg(CFG_INTERVAL, 5'd30);
        write_reg(CFG_ACTIVE, 5'd8);
        steady = 1'b1;
        run_random(250, -1);
        steady = 1'b0;

        write_reg(CFG_ACTIVE, 5'd15);
        write_reg(CFG_INTERVAL, 5'd15);
        write_reg(CFG_INTERVAL, 5'd2);
        run_random(250, -1);

        write_reg(CFG_ACTIVE, 5'd0);
        run_random(40, -1);

        // Random settings; the input pauses midway until every result is back.
        write_reg(CFG_ACTIVE, CFG_DATA_W'($urandom_range(1, 15)));
        write_reg(CFG_INTERVAL, CFG_DATA_W'($urandom_range(0, 31)));
        write_reg(CFG_INTERVAL, 5'd5);
        run_random(420, 200);

        wait_until_drained();
        repeat (10) @(posedge clk);

        $display("Ran %0d words and %0d register writes: %0d fetch grants, %0d failed reports,",
                 words_sent, reg_writes, grants, failed_reports);
        $display("%0d words on slots out of range, %0d results compared, one %0d-cycle stall.",
                 inactive_words, results_seen, HOLD_CYCLES);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
